### hw/rtl/tmcg_pkg.sv
// Shared constants and types of the torus map chaos generator.
`timescale 1ns / 1ps

package tmcg_pkg;

	// 2*pi in Q4.60; the Q30 pi constants are rounded from it
	localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
	localparam logic [63:0] PI_Q30      = (TWO_PI_Q60 + (64'd1 << 30)) >> 31;
	localparam logic [63:0] HALF_PI_Q30 = (TWO_PI_Q60 + (64'd1 << 31)) >> 32;
	localparam logic [63:0] TWO_PI_Q30  = (TWO_PI_Q60 + (64'd1 << 29)) >> 30;

	// CORDIC start vector (1/gain), Q2.30
	localparam logic signed [32:0] INV_GAIN_Q30 = 33'sh026DD3B6A;

	localparam int SIN_W = 33;   // CORDIC vector width
	localparam int SUM_W = 34;   // pre-remainder sum width
	localparam int ATAN_LEN = 30;

	typedef logic [4:0] atan_idx_t;

	// arctan(2^-i), truncated to Q2.30
	localparam logic [31:0] ATAN_Q30 [ATAN_LEN] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
		32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
		32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
		32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
	};

	typedef enum logic [2:0] {
		CMD_STEP   = 3'd0,
		CMD_RELOAD = 3'd1,
		CMD_LOAD_X = 3'd2,
		CMD_LOAD_Y = 3'd3,
		CMD_LOAD_C = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		REG_X_INIT = 2'd0,
		REG_Y_INIT = 2'd1,
		REG_C_INIT = 2'd2,
		REG_ECHO   = 2'd3
	} cfg_reg_t;

	// handshake between sequencer and an iterative unit
	typedef struct packed {
		logic start;
	} unit_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

endpackage

### hw/rtl/tmcg_cordic.sv
// Iterative rotation-mode CORDIC sine with quadrant folding, one micro-rotation per cycle.
`timescale 1ns / 1ps

module tmcg_cordic #(
	parameter int FRAC_BITS = 28,
	parameter int ITERATIONS = 24
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tmcg_pkg::unit_ctl_t                ctl,
	input  logic signed [31:0]                 angle,
	output tmcg_pkg::unit_sts_t                sts,
	output logic signed [tmcg_pkg::SIN_W-1:0]  sine
);

	localparam int ZW = 64 - FRAC_BITS;
	localparam int IW = $clog2(ITERATIONS);
	localparam logic signed [ZW-1:0] PI_Z      = ZW'(tmcg_pkg::PI_Q30);
	localparam logic signed [ZW-1:0] HALF_PI_Z = ZW'(tmcg_pkg::HALF_PI_Q30);
	localparam logic signed [ZW-1:0] TWO_PI_Z  = ZW'(tmcg_pkg::TWO_PI_Q30);

	typedef enum logic [1:0] {IDLE, FOLD, RUN} cst_t;

	cst_t                              state_q;
	logic signed [ZW-1:0]              z_q;
	logic signed [tmcg_pkg::SIN_W-1:0] cx_q, cy_q;
	logic [IW-1:0]                     iter_q;
	logic                              done_q;

	logic signed [ZW-1:0]              z_ext, z_turn, z_half, atan_z;
	logic signed [tmcg_pkg::SIN_W-1:0] sx, sy;

	// Q.F -> Q2.30, then one turn off
	assign z_ext = ZW'(angle) <<< (30 - FRAC_BITS);

	always_comb begin
		if (z_ext > PI_Z) begin
			z_turn = z_ext - TWO_PI_Z;
		end else if (z_ext < -PI_Z) begin
			z_turn = z_ext + TWO_PI_Z;
		end else begin
			z_turn = z_ext;
		end
	end

	// mirror into [-pi/2, pi/2]
	always_comb begin
		if (z_q > HALF_PI_Z) begin
			z_half = PI_Z - z_q;
		end else if (z_q < -HALF_PI_Z) begin
			z_half = -PI_Z - z_q;
		end else begin
			z_half = z_q;
		end
	end

	assign atan_z = ZW'($signed(tmcg_pkg::ATAN_Q30[tmcg_pkg::atan_idx_t'(iter_q)]));
	assign sx = cy_q >>> iter_q;
	assign sy = cx_q >>> iter_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			done_q  <= 1'b0;
			iter_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (ctl.start) begin
						z_q     <= z_turn;
						state_q <= FOLD;
					end
				end
				FOLD: begin
					z_q     <= z_half;
					cx_q    <= tmcg_pkg::INV_GAIN_Q30;
					cy_q    <= '0;
					iter_q  <= '0;
					state_q <= RUN;
				end
				RUN: begin
					if (!z_q[ZW-1]) begin
						cx_q <= cx_q - sx;
						cy_q <= cy_q + sy;
						z_q  <= z_q - atan_z;
					end else begin
						cx_q <= cx_q + sx;
						cy_q <= cy_q - sy;
						z_q  <= z_q + atan_z;
					end
					iter_q <= iter_q + 1'b1;
					if (iter_q == IW'(ITERATIONS - 1)) begin
						done_q  <= 1'b1;
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign sts.busy = (state_q != IDLE);
	assign sts.done = done_q;
	assign sine     = cy_q;

endmodule

### hw/rtl/tmcg_rem.sv
// Iterative truncating remainder by 2*pi: one restoring compare/subtract per cycle.
`timescale 1ns / 1ps

module tmcg_rem #(
	parameter int FRAC_BITS = 28
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  tmcg_pkg::unit_ctl_t                ctl,
	input  logic signed [tmcg_pkg::SUM_W-1:0]  operand,
	output tmcg_pkg::unit_sts_t                sts,
	output logic signed [31:0]                 result
);

	localparam int SW = tmcg_pkg::SUM_W;
	// 2*pi >= 2^(F+2) and |operand| <= 2^33, so this many divisor positions
	localparam int STEPS = 31 - FRAC_BITS;
	localparam int CW = $clog2(STEPS + 1);
	localparam logic [63:0] TWO_PI_F =
		(tmcg_pkg::TWO_PI_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS);
	localparam logic [SW-1:0] DVS_TOP = SW'(TWO_PI_F << (STEPS - 1));

	logic            busy_q, done_q, sign_q;
	logic [SW-1:0]   mag_q, dvs_q;
	logic [CW-1:0]   cnt_q;
	logic [SW-1:0]   res_mag;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q) begin
				if (ctl.start) begin
					sign_q <= operand[SW-1];
					mag_q  <= operand[SW-1] ? SW'(-operand) : SW'(operand);
					dvs_q  <= DVS_TOP;
					cnt_q  <= CW'(STEPS);
					busy_q <= 1'b1;
				end
			end else begin
				if (mag_q >= dvs_q) begin
					mag_q <= mag_q - dvs_q;
				end
				dvs_q <= dvs_q >> 1;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// sign of the dividend is kept
	assign res_mag  = sign_q ? (~mag_q + 1'b1) : mag_q;
	assign result   = res_mag[31:0];
	assign sts.busy = busy_q;
	assign sts.done = done_q;

endmodule

### hw/rtl/torus_map_chaos_generator.sv
// Output: a step or echoed load enters EMIT, which registers its result request.
// Busy: a step (or echoed load) holds the input off through EMIT, the CORDIC
//   fold and micro-rotations, the multiply and rounding, then two remainder
//   passes through the shared compare/subtract unit. Others leave it ready.
// Reset: asynchronous, active low; init registers return to 0.777, 1.2, 1.26 and
//   echo off, and the map state is loaded from those values. No clearing pass.
`timescale 1ns / 1ps

module torus_map_chaos_generator #(
	parameter int FRAC_BITS = 28,
	parameter int SINE_ITERATIONS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	// command requests
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] load_value
	input  logic [2:0]  s_axis_tuser,   // [2:0] cmd
	// result requests
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,   // [31:0] x_out, [63:32] y_out
	// configuration
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int SW = tmcg_pkg::SUM_W;
	localparam int PW = 32 + tmcg_pkg::SIN_W;

	// reset values of the init registers, rounded to nearest at FRAC_BITS
	localparam logic [31:0] X_INIT_RST = 32'(((64'd777 << FRAC_BITS) + 64'd500) / 64'd1000);
	localparam logic [31:0] Y_INIT_RST = 32'(((64'd12 << FRAC_BITS) + 64'd5) / 64'd10);
	localparam logic [31:0] C_INIT_RST = 32'(((64'd126 << FRAC_BITS) + 64'd50) / 64'd100);

	typedef enum logic [2:0] {
		IDLE, EMIT, SINE, MUL, RND, REM_Y, REM_X
	} st_t;

	st_t                 state_q;
	logic signed [31:0]  x_init_q, y_init_q, c_init_q;
	logic                echo_q;
	logic signed [31:0]  x_q, y_q, coupling_q, y_next_q;
	logic signed [PW-1:0] prod_q;
	logic signed [32:0]  term_q;
	logic                m_valid_q;
	logic [63:0]         m_data_q;

	tmcg_pkg::unit_ctl_t sin_ctl, rem_ctl;
	tmcg_pkg::unit_sts_t sin_sts, rem_sts;
	logic signed [tmcg_pkg::SIN_W-1:0] sine;
	logic signed [31:0]  rem_res;
	logic signed [SW-1:0] sum_x, sum_y, rem_op;
	logic signed [PW-1:0] prod_rnd;
	logic                in_fire, emit_fire;
	tmcg_pkg::cmd_t      cmd;

	assign cmd       = tmcg_pkg::cmd_t'(s_axis_tuser);
	assign s_axis_tready = (state_q == IDLE);
	assign in_fire   = s_axis_tvalid && s_axis_tready;
	// output register free, or its request leaves this cycle
	assign emit_fire = (state_q == EMIT) && (!m_valid_q || m_axis_tready);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_init_q <= X_INIT_RST;
			y_init_q <= Y_INIT_RST;
			c_init_q <= C_INIT_RST;
			echo_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (tmcg_pkg::cfg_reg_t'(cfg_index))
				tmcg_pkg::REG_X_INIT: x_init_q <= cfg_data;
				tmcg_pkg::REG_Y_INIT: y_init_q <= cfg_data;
				tmcg_pkg::REG_C_INIT: c_init_q <= cfg_data;
				tmcg_pkg::REG_ECHO:   echo_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sine of y; y_q stays put until the step completes
	assign sin_ctl.start = emit_fire;

	tmcg_cordic #(
		.FRAC_BITS (FRAC_BITS),
		.ITERATIONS(SINE_ITERATIONS)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (sin_ctl),
		.angle (y_q),
		.sts   (sin_sts),
		.sine  (sine)
	);

	// product rounded to nearest (ties up) from Q(F+30) to Q.F
	assign prod_rnd = prod_q + PW'(64'd1 << 29);
	assign sum_y = SW'(x_q) + SW'(y_q);
	assign sum_x = SW'(x_q) + SW'(term_q);

	// the remainder unit is shared: y' first, then x'
	assign rem_op        = (state_q == RND) ? sum_y : sum_x;
	assign rem_ctl.start = (state_q == RND) || ((state_q == REM_Y) && rem_sts.done);

	tmcg_rem #(
		.FRAC_BITS(FRAC_BITS)
	) u_rem (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (rem_ctl),
		.operand(rem_op),
		.sts    (rem_sts),
		.result (rem_res)
	);

	// step sequencer, map state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= IDLE;
			m_valid_q  <= 1'b0;
			x_q        <= X_INIT_RST;
			y_q        <= Y_INIT_RST;
			coupling_q <= C_INIT_RST;
		end else begin
			if (emit_fire) begin
				m_valid_q <= 1'b1;
				m_data_q  <= {y_q, x_q};
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end

			unique case (state_q)
				IDLE: begin
					if (in_fire) begin
						case (cmd)
							tmcg_pkg::CMD_STEP: state_q <= EMIT;
							tmcg_pkg::CMD_RELOAD: begin
								x_q        <= x_init_q;
								y_q        <= y_init_q;
								coupling_q <= c_init_q;
							end
							tmcg_pkg::CMD_LOAD_X: begin
								x_q     <= s_axis_tdata;
								state_q <= echo_q ? EMIT : IDLE;
							end
							tmcg_pkg::CMD_LOAD_Y: begin
								y_q     <= s_axis_tdata;
								state_q <= echo_q ? EMIT : IDLE;
							end
							tmcg_pkg::CMD_LOAD_C: begin
								coupling_q <= s_axis_tdata;
								state_q    <= echo_q ? EMIT : IDLE;
							end
							default: ;  // unused codes are dropped
						endcase
					end
				end
				EMIT: begin
					if (emit_fire) begin
						state_q <= SINE;
					end
				end
				SINE: begin
					if (sin_sts.done) begin
						state_q <= MUL;
					end
				end
				MUL: begin
					prod_q  <= PW'(coupling_q) * PW'(sine);
					state_q <= RND;
				end
				RND: begin
					term_q  <= 33'(prod_rnd >>> 30);
					state_q <= REM_Y;
				end
				REM_Y: begin
					if (rem_sts.done) begin
						y_next_q <= rem_res;
						state_q  <= REM_X;
					end
				end
				REM_X: begin
					if (rem_sts.done) begin
						x_q     <= rem_res;
						y_q     <= y_next_q;
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

endmodule

### bench/tmcg_checker.sv
// Checker for the torus map generator: tracks command, result and register traffic, predicts, compares.
`timescale 1ns / 1ps

module tmcg_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // [31:0] load_value
	input  logic [2:0]  s_axis_tuser,   // [2:0] cmd
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [63:0] m_axis_tdata,   // [31:0] x_out, [63:32] y_out
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	output int          mismatches,
	output int          outstanding,
	output int          checked
);

	localparam int FRAC_BITS = 28;
	localparam int SINE_ITERATIONS = 24;
	localparam int MAX_REPORTS = 40;

	localparam logic [63:0] TURN_Q60 = 64'h6487ED5110B4611A;
	localparam longint TURN_F =
		longint'((TURN_Q60 + (64'd1 << (59 - FRAC_BITS))) >> (60 - FRAC_BITS));
	localparam longint TURN_Q30         = longint'((TURN_Q60 + (64'd1 << 29)) >> 30);
	localparam longint HALF_TURN_Q30    = longint'((TURN_Q60 + (64'd1 << 30)) >> 31);
	localparam longint QUARTER_TURN_Q30 = longint'((TURN_Q60 + (64'd1 << 31)) >> 32);
	localparam longint CORDIC_START     = 64'h26DD3B6A;

	localparam longint ARCTAN_Q30 [30] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
		32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
		32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
		32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
		32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002
	};

	localparam logic [31:0] X_INIT_RST = 32'd208574349;
	localparam logic [31:0] Y_INIT_RST = 32'd322122547;
	localparam logic [31:0] C_INIT_RST = 32'd338228675;

	typedef struct packed {
		logic [31:0] y;
		logic [31:0] x;
	} angle_pair_t;

	angle_pair_t       emitted_q[$];
	logic [31:0]       x_init, y_init, c_init;
	logic              echo;
	logic signed [31:0] x_ang, y_ang, coup;

	// sine of a Q4.28 angle in Q2.30, folded to +-pi/2 first
	function automatic longint cordic_sine(input longint ang);
		longint z, cx, cy, nx;
		z = ang * (longint'(1) << (30 - FRAC_BITS));
		cx = CORDIC_START;
		cy = 0;
		if (z > HALF_TURN_Q30)
			z -= TURN_Q30;
		else if (z < -HALF_TURN_Q30)
			z += TURN_Q30;
		if (z > QUARTER_TURN_Q30)
			z = HALF_TURN_Q30 - z;
		else if (z < -QUARTER_TURN_Q30)
			z = -HALF_TURN_Q30 - z;
		for (int i = 0; i < SINE_ITERATIONS && i < 30; i++) begin
			if (z >= 0) begin
				nx = cx - (cy >>> i);
				cy = cy + (cx >>> i);
				z -= ARCTAN_Q30[i];
			end else begin
				nx = cx + (cy >>> i);
				cy = cy - (cx >>> i);
				z += ARCTAN_Q30[i];
			end
			cx = nx;
		end
		return cy;
	endfunction

	// queue the current angles, then move one map iteration
	task automatic emit_and_iterate();
		angle_pair_t e;
		longint term, nx, ny;
		e.x = x_ang;
		e.y = y_ang;
		emitted_q.push_back(e);
		term = (longint'(coup) * cordic_sine(longint'(y_ang)) + (longint'(1) << 29)) >>> 30;
		nx = (longint'(x_ang) + term) % TURN_F;
		ny = (longint'(x_ang) + longint'(y_ang)) % TURN_F;
		x_ang = nx[31:0];
		y_ang = ny[31:0];
	endtask

	always @(posedge clk or negedge arst_n) begin
		angle_pair_t want;
		if (!arst_n) begin
			x_init = X_INIT_RST;
			y_init = Y_INIT_RST;
			c_init = C_INIT_RST;
			echo = 1'b0;
			x_ang = X_INIT_RST;
			y_ang = Y_INIT_RST;
			coup = C_INIT_RST;
			emitted_q.delete();
			mismatches = 0;
			checked = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					tmcg_pkg::REG_X_INIT: x_init = cfg_data;
					tmcg_pkg::REG_Y_INIT: y_init = cfg_data;
					tmcg_pkg::REG_C_INIT: c_init = cfg_data;
					tmcg_pkg::REG_ECHO:   echo = cfg_data[0];
					default: ;
				endcase
			end

			if (s_axis_tvalid && s_axis_tready) begin
				case (s_axis_tuser)
					tmcg_pkg::CMD_STEP: emit_and_iterate();
					tmcg_pkg::CMD_RELOAD: begin
						x_ang = x_init;
						y_ang = y_init;
						coup = c_init;
					end
					tmcg_pkg::CMD_LOAD_X: begin
						x_ang = s_axis_tdata;
						if (echo) emit_and_iterate();
					end
					tmcg_pkg::CMD_LOAD_Y: begin
						y_ang = s_axis_tdata;
						if (echo) emit_and_iterate();
					end
					tmcg_pkg::CMD_LOAD_C: begin
						coup = s_axis_tdata;
						if (echo) emit_and_iterate();
					end
					default: ;
				endcase
			end

			if (m_axis_tvalid && m_axis_tready) begin
				if (emitted_q.size() == 0) begin
					if (mismatches < MAX_REPORTS)
						$display("%0t: stray result x_out=%h y_out=%h, nothing expected",
							$time, m_axis_tdata[31:0], m_axis_tdata[63:32]);
					mismatches++;
				end else begin
					want = emitted_q.pop_front();
					checked++;
					if (m_axis_tdata[31:0] !== want.x) begin
						if (mismatches < MAX_REPORTS)
							$display("%0t: x_out expected %h, got %h",
								$time, want.x, m_axis_tdata[31:0]);
						mismatches++;
					end
					if (m_axis_tdata[63:32] !== want.y) begin
						if (mismatches < MAX_REPORTS)
							$display("%0t: y_out expected %h, got %h",
								$time, want.y, m_axis_tdata[63:32]);
						mismatches++;
					end
				end
			end
			outstanding <= emitted_q.size();
		end
	end

endmodule

### bench/tb_top.sv
// Top of the torus map generator bench: clock, reset, command and register stimulus, verdict.
`timescale 1ns / 1ps

module tb_top;

	// angle constants in Q4.28
	localparam longint TURN_F    = 1686629713;
	localparam longint PI_F      = 843314857;
	localparam longint HALF_PI_F = 421657428;

	// command codes the block must ignore
	localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

	localparam int NUM_PHASES      = 8;
	localparam int ITEMS_PER_PHASE = 212;
	localparam int SETTLE_CYCLES   = 64;    // covers a step still running after its result
	localparam int DRAIN_LIMIT     = 20000;

	typedef enum {V_FULL, V_TURN, V_EDGE, V_UNIT} value_kind_t;
	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;                  // [31:0] load_value
	logic [2:0]  s_axis_tuser = tmcg_pkg::CMD_STEP;  // [2:0] cmd
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;                       // [31:0] x_out, [63:32] y_out
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = tmcg_pkg::REG_X_INIT;
	logic [31:0] cfg_data = '0;

	int mismatches, outstanding, checked;

	// stimulus bookkeeping for the summary
	int n_steps = 0, n_loads = 0, n_reloads = 0, n_spare = 0, n_settings = 0;
	int burst_left = 0;

	rx_mode_t rx_mode = RX_OPEN;
	int       rx_left = 0;

	torus_map_chaos_generator uut (.*);
	tmcg_checker u_checker (.*);

	always #6 clk = ~clk;

	// Result side: back-pressure switches at random between modes, from wide open
	// to coin flips, sparse accepts and a fixed beat.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = $urandom_range(50, 400);
		end else begin
			rx_left--;
		end
		case (rx_mode)
			RX_OPEN:   m_axis_tready <= 1'b1;
			RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
			RX_SPARSE: m_axis_tready <= ($urandom_range(0, 4) == 0);
			default:   m_axis_tready <= rx_left[2];
		endcase
	end

	// Load values: anything, inside one turn, the edges, or within +-1.0
	function automatic logic [31:0] pick_value(input value_kind_t kind);
		longint v;
		case (kind)
			V_FULL: v = $urandom;
			V_TURN: v = longint'($urandom_range(0, 32'(2 * TURN_F))) - TURN_F;
			V_EDGE: begin
				case ($urandom_range(0, 7))
					0: v = 32'h7FFFFFFF;
					1: v = 32'h80000000;
					2: v = 0;
					3: v = 32'hFFFFFFFF;
					4: v = TURN_F;
					5: v = -TURN_F;
					6: v = PI_F;
					default: v = -PI_F;
				endcase
			end
			default: v = longint'($urandom_range(0, 32'd1 << 29)) - (longint'(1) << 28);
		endcase
		return v[31:0];
	endfunction

	// One command request; returns at the edge where it was taken, tvalid still high.
	task automatic send_cmd(input logic [2:0] code, input logic [31:0] value);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= code;
		s_axis_tdata <= value;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		case (code)
			tmcg_pkg::CMD_STEP:   n_steps++;
			tmcg_pkg::CMD_RELOAD: n_reloads++;
			tmcg_pkg::CMD_LOAD_X, tmcg_pkg::CMD_LOAD_Y, tmcg_pkg::CMD_LOAD_C: n_loads++;
			default:    n_spare++;
		endcase
	endtask

	// Sender pacing: back-to-back bursts, then a gap (now and then a long one
	// so that it lands deep inside a step's busy window).
	task automatic pace();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(0, 24);
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 45) : $urandom_range(1, 6);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending, wait for every expected result, then let a running step finish.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input tmcg_pkg::cfg_reg_t idx, input logic [31:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Only bit 0 of the echo register matters; upper bits are junk on purpose.
	task automatic configure(input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] c, input logic echo);
		write_reg(tmcg_pkg::REG_X_INIT, x);
		write_reg(tmcg_pkg::REG_Y_INIT, y);
		write_reg(tmcg_pkg::REG_C_INIT, c);
		write_reg(tmcg_pkg::REG_ECHO, ($urandom & ~32'd1) | 32'(echo));
		n_settings++;
	endtask

	initial begin
		int r, done, wait_cnt;
		logic [2:0] code;
		logic [31:0] value;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset values, saturated angle loads, coupling extremes,
		// reload, unused codes, then echo mode with pi boundaries.
		send_cmd(tmcg_pkg::CMD_STEP, 32'h0);                 pace();
		send_cmd(tmcg_pkg::CMD_STEP, 32'hFFFFFFFF);          pace();
		send_cmd(tmcg_pkg::CMD_LOAD_X, 32'h7FFFFFFF);        pace();
		send_cmd(tmcg_pkg::CMD_LOAD_Y, 32'h80000000);        pace();
		send_cmd(tmcg_pkg::CMD_STEP, 32'h0);                 pace();
		send_cmd(tmcg_pkg::CMD_STEP, 32'h0);                 pace();
		send_cmd(tmcg_pkg::CMD_LOAD_C, 32'h80000000);        pace();
		send_cmd(tmcg_pkg::CMD_LOAD_Y, 32'h7FFFFFFF);        pace();
		send_cmd(tmcg_pkg::CMD_STEP, 32'h0);                 pace();
		send_cmd(tmcg_pkg::CMD_RELOAD, 32'h0);               pace();
		send_cmd(tmcg_pkg::CMD_STEP, 32'h0);                 pace();
		send_cmd(CMD_SPARE_FIRST, 32'hFFFFFFFF);             pace();
		send_cmd(3'd6, 32'hFFFFFFFF);                        pace();
		send_cmd(CMD_SPARE_LAST, 32'hFFFFFFFF);              pace();
		send_cmd(tmcg_pkg::CMD_STEP, 32'h0);                 pace();
		settle();

		configure(32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 1'b1);
		send_cmd(tmcg_pkg::CMD_RELOAD, 32'h0);               pace();
		send_cmd(tmcg_pkg::CMD_STEP, 32'h0);                 pace();
		send_cmd(tmcg_pkg::CMD_LOAD_Y, 32'(PI_F));           pace();
		send_cmd(tmcg_pkg::CMD_LOAD_Y, 32'(-PI_F));          pace();
		send_cmd(tmcg_pkg::CMD_LOAD_Y, 32'(-HALF_PI_F));     pace();
		send_cmd(tmcg_pkg::CMD_LOAD_C, 32'h0);               pace();
		send_cmd(tmcg_pkg::CMD_LOAD_X, 32'hFFFFFFFF);        pace();
		send_cmd(tmcg_pkg::CMD_LOAD_C, 32'h7FFFFFFF);        pace();
		send_cmd(tmcg_pkg::CMD_STEP, 32'h0);                 pace();
		send_cmd(CMD_SPARE_LAST, 32'h0);                     pace();
		settle();

		// Random phases: each gets its own register setting (extremes first),
		// starts from a reload and is mostly steps so the map runs deep.
		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: configure(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b0);
				1: configure(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 1'b1);
				2: configure(32'h0, 32'h0, 32'h0, 1'b0);
				default: configure(pick_value(value_kind_t'($urandom_range(0, 3))),
					pick_value(value_kind_t'($urandom_range(0, 3))),
					pick_value(value_kind_t'($urandom_range(0, 3))),
					1'($urandom_range(0, 1)));
			endcase
			send_cmd(tmcg_pkg::CMD_RELOAD, $urandom);
			pace();
			done = 1;
			while (done < ITEMS_PER_PHASE) begin
				r = $urandom_range(0, 99);
				if (r < 60)      code = tmcg_pkg::CMD_STEP;
				else if (r < 67) code = tmcg_pkg::CMD_RELOAD;
				else if (r < 75) code = tmcg_pkg::CMD_LOAD_X;
				else if (r < 83) code = tmcg_pkg::CMD_LOAD_Y;
				else if (r < 93) code = tmcg_pkg::CMD_LOAD_C;
				else             code = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
				r = $urandom_range(0, 99);
				case (code)
					tmcg_pkg::CMD_LOAD_X, tmcg_pkg::CMD_LOAD_Y:
						value = pick_value(r < 70 ? V_TURN : (r < 85 ? V_FULL : V_EDGE));
					tmcg_pkg::CMD_LOAD_C:
						value = pick_value(r < 60 ? V_UNIT : (r < 85 ? V_FULL : V_EDGE));
					default: value = $urandom;
				endcase
				send_cmd(code, value);
				done++;
				// now and then hold off until the result side has caught up
				if ($urandom_range(0, 149) == 0)
					settle();
				else
					pace();
			end
			settle();
		end

		// Final drain: everything predicted must come out.
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		wait_cnt = 0;
		while (outstanding != 0 && wait_cnt < DRAIN_LIMIT) begin
			@(posedge clk);
			wait_cnt++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (outstanding != 0)
			$display("%0t: %0d expected results never arrived", $time, outstanding);

		$display("Sent %0d commands: %0d steps, %0d loads, %0d reloads, %0d unused codes",
			n_steps + n_loads + n_reloads + n_spare, n_steps, n_loads, n_reloads, n_spare);
		$display("Ran %0d register settings; %0d results compared, %0d mismatches",
			n_settings, checked, mismatches);
		if (mismatches == 0 && outstanding == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#12_000_000;
		$display("%0t: run did not finish in time", $time);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
